FILE: sv/adl_pkg.sv
// Shared types, codes and constants of the array-based doubly linked list.
package adl_pkg;

    localparam int SLOTS     = 16;
    localparam int TAG_BITS  = 32;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int CNT_BITS  = $clog2(SLOTS + 1);

    typedef logic [SLOT_BITS-1:0] slot_t;
    // A link carries one extra bit; the value SLOTS marks the null link.
    typedef logic [SLOT_BITS:0]   link_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [TAG_BITS-1:0]  tag_t;

    localparam link_t LINK_NULL = link_t'(SLOTS);

    // Operation codes.
    localparam logic [3:0] OP_ADD_FIRST = 4'd0;
    localparam logic [3:0] OP_ADD_AFTER = 4'd1;
    localparam logic [3:0] OP_ADD_LAST  = 4'd2;
    localparam logic [3:0] OP_DEL_FIRST = 4'd3;
    localparam logic [3:0] OP_DEL_AFTER = 4'd4;
    localparam logic [3:0] OP_DEL_LAST  = 4'd5;
    localparam logic [3:0] OP_DEL_ALL   = 4'd6;
    localparam logic [3:0] OP_WALK_FWD  = 4'd7;
    localparam logic [3:0] OP_WALK_BACK = 4'd8;
    localparam logic [3:0] OP_REVERSE   = 4'd9;
    localparam logic [3:0] OP_COUNT     = 4'd10;

    // Result status codes.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_ANCHOR = 2'd3;

    typedef struct packed {
        logic [3:0] opcode;
        slot_t      anchor_slot;
        tag_t       tag_a;
        tag_t       tag_b;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        slot_t      slot;
        tag_t       out_tag_a;
        tag_t       out_tag_b;
        cnt_t       length;
        logic       last;
    } rsp_t;

    // Lowest free slot, as found by the free-slot finder.
    typedef struct packed {
        logic  found;
        slot_t slot;
    } free_info_t;

    // Builds a single final result; the length is filled in when it is sent.
    function automatic rsp_t mk_res(logic [1:0] st, slot_t sl, tag_t ta, tag_t tb);
        rsp_t r;
        r.status    = st;
        r.slot      = sl;
        r.out_tag_a = ta;
        r.out_tag_b = tb;
        r.length    = '0;
        r.last      = 1'b1;
        return r;
    endfunction

endpackage

FILE: sv/array_doubly_linked_list.sv
// Top level of the array-based doubly linked list with its link and payload memories.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------------
//  req     | in        | req_valid, req_stall | opcode, anchor_slot, tag_a, tag_b
//  rsp     | out       | rsp_valid, rsp_stall | status, slot, tags, length, last
//
// One transaction is worked on at a time; req_stall is high until its last result
// has been loaded into the output register. Inserts and deletes are read-modify-write
// sequences on the link memory; a walk reads each element and then sends it, and
// reverse reads and swaps the tags of element pairs from both ends inwards.
// Reset clears the used marks, head, tail and count at once; the memories need no
// clearing pass. A stalled rsp holds the result in place and lengthens the transaction.
module array_doubly_linked_list (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  adl_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output adl_pkg::rsp_t  rsp
);
    import adl_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_INS_RD   = 4'd2;
    localparam logic [3:0] S_INS_WR   = 4'd3;
    localparam logic [3:0] S_INS_A    = 4'd4;
    localparam logic [3:0] S_INS_N    = 4'd5;
    localparam logic [3:0] S_DA_RD    = 4'd6;
    localparam logic [3:0] S_DEL_RD   = 4'd7;
    localparam logic [3:0] S_DEL_N    = 4'd8;
    localparam logic [3:0] S_WALK_RD  = 4'd9;
    localparam logic [3:0] S_WALK_OUT = 4'd10;
    localparam logic [3:0] S_REV_RF   = 4'd11;
    localparam logic [3:0] S_REV_RB   = 4'd12;
    localparam logic [3:0] S_REV_WF   = 4'd13;
    localparam logic [3:0] S_REV_WB   = 4'd14;
    localparam logic [3:0] S_EMIT     = 4'd15;

    logic [3:0]       state_reg, state_next;
    logic [3:0]       op_reg, op_next;
    slot_t            anchor_reg, anchor_next;
    tag_t             tag_a_reg, tag_a_next;
    tag_t             tag_b_reg, tag_b_next;
    logic [SLOTS-1:0] used_reg, used_next;
    link_t            head_reg, head_next;
    link_t            tail_reg, tail_next;
    cnt_t             count_reg, count_next;
    slot_t            s_reg, s_next;
    link_t            a_reg, a_next;
    link_t            n_reg, n_next;
    link_t            p_reg, p_next;
    link_t            front_reg, front_next;
    link_t            back_reg, back_next;
    slot_t            k_reg, k_next;
    cnt_t             i_reg, i_next;
    tag_t             swap_a_reg, swap_a_next;
    tag_t             swap_b_reg, swap_b_next;
    rsp_t             res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;

    // Memory ports.
    logic             link_rd_en;
    slot_t            link_rd_addr;
    logic             link_we_next;
    logic             link_we_prev;
    slot_t            link_wr_addr;
    link_t            link_wd_next;
    link_t            link_wd_prev;
    logic             pay_rd_en;
    slot_t            pay_rd_addr;
    logic             pay_we;
    slot_t            pay_wr_addr;
    tag_t             pay_wd_a;
    tag_t             pay_wd_b;

    link_t            next_mem [SLOTS];
    link_t            prev_mem [SLOTS];
    tag_t             pa_mem [SLOTS];
    tag_t             pb_mem [SLOTS];
    link_t            rd_next_reg;
    link_t            rd_prev_reg;
    tag_t             rd_a_reg;
    tag_t             rd_b_reg;

    free_info_t       free_info;
    logic             out_free;
    link_t            walk_nx;
    logic             walk_fin;
    link_t            ins_anchor;

    adl_free_find u_free_find (
        .used (used_reg),
        .info (free_info)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;

    // Link memory: two lanes with their own write enables, one shared read port.
    always_ff @(posedge clk)
    begin
        if (link_we_next)
        begin
            next_mem[link_wr_addr] <= link_wd_next;
        end
        if (link_we_prev)
        begin
            prev_mem[link_wr_addr] <= link_wd_prev;
        end
        if (link_rd_en)
        begin
            rd_next_reg <= next_mem[link_rd_addr];
            rd_prev_reg <= prev_mem[link_rd_addr];
        end
    end

    // Payload memory holding both tags of each slot.
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pa_mem[pay_wr_addr] <= pay_wd_a;
            pb_mem[pay_wr_addr] <= pay_wd_b;
        end
        if (pay_rd_en)
        begin
            rd_a_reg <= pa_mem[pay_rd_addr];
            rd_b_reg <= pb_mem[pay_rd_addr];
        end
    end

    // Walk step: the neighbour in the walking direction and the final-result mark.
    assign walk_nx  = (op_reg == OP_WALK_FWD) ? rd_next_reg : rd_prev_reg;
    assign walk_fin = walk_nx[SLOT_BITS] || (k_reg == slot_t'(SLOTS - 1));

    // Anchor of an insert: null for the head, the given slot, or the tail.
    always_comb
    begin
        case (op_reg)
            OP_ADD_FIRST: ins_anchor = LINK_NULL;
            OP_ADD_AFTER: ins_anchor = {1'b0, anchor_reg};
            default:      ins_anchor = tail_reg;
        endcase
    end

    // Sequencer: one state per step of the link and payload memory accesses of an operation.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        anchor_next    = anchor_reg;
        tag_a_next     = tag_a_reg;
        tag_b_next     = tag_b_reg;
        used_next      = used_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        s_next         = s_reg;
        a_next         = a_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        swap_a_next    = swap_a_reg;
        swap_b_next    = swap_b_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;

        link_rd_en   = 1'b0;
        link_rd_addr = '0;
        link_we_next = 1'b0;
        link_we_prev = 1'b0;
        link_wr_addr = '0;
        link_wd_next = LINK_NULL;
        link_wd_prev = LINK_NULL;
        pay_rd_en    = 1'b0;
        pay_rd_addr  = '0;
        pay_we       = 1'b0;
        pay_wr_addr  = '0;
        pay_wd_a     = '0;
        pay_wd_b     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.opcode;
                    anchor_next = req.anchor_slot;
                    tag_a_next  = req.tag_a;
                    tag_b_next  = req.tag_b;
                    state_next  = S_START;
                end
            end

            S_START:
            begin
                case (op_reg)
                    OP_ADD_FIRST, OP_ADD_AFTER, OP_ADD_LAST:
                    begin
                        if (count_reg == cnt_t'(SLOTS) || !free_info.found)
                        begin
                            res_next   = mk_res(STAT_FULL, '0, '0, '0);
                            state_next = S_EMIT;
                        end
                        else if (op_reg == OP_ADD_AFTER && !used_reg[anchor_reg])
                        begin
                            res_next   = mk_res(STAT_ANCHOR, anchor_reg, '0, '0);
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            s_next = free_info.slot;
                            a_next = ins_anchor;
                            if (!ins_anchor[SLOT_BITS])
                            begin
                                link_rd_en   = 1'b1;
                                link_rd_addr = ins_anchor[SLOT_BITS-1:0];
                                state_next   = S_INS_RD;
                            end
                            else
                            begin
                                n_next     = head_reg;
                                state_next = S_INS_WR;
                            end
                        end
                    end

                    OP_DEL_FIRST, OP_DEL_LAST:
                    begin
                        if ((op_reg == OP_DEL_FIRST) ? head_reg[SLOT_BITS]
                                                     : tail_reg[SLOT_BITS])
                        begin
                            res_next   = mk_res(STAT_EMPTY, '0, '0, '0);
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            s_next       = (op_reg == OP_DEL_FIRST)
                                           ? head_reg[SLOT_BITS-1:0]
                                           : tail_reg[SLOT_BITS-1:0];
                            link_rd_en   = 1'b1;
                            link_rd_addr = s_next;
                            pay_rd_en    = 1'b1;
                            pay_rd_addr  = s_next;
                            state_next   = S_DEL_RD;
                        end
                    end

                    OP_DEL_AFTER:
                    begin
                        if (!used_reg[anchor_reg])
                        begin
                            res_next   = mk_res(STAT_ANCHOR, anchor_reg, '0, '0);
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            link_rd_en   = 1'b1;
                            link_rd_addr = anchor_reg;
                            state_next   = S_DA_RD;
                        end
                    end

                    OP_DEL_ALL:
                    begin
                        used_next  = '0;
                        head_next  = LINK_NULL;
                        tail_next  = LINK_NULL;
                        count_next = '0;
                        res_next   = mk_res(STAT_OK, '0, '0, '0);
                        state_next = S_EMIT;
                    end

                    OP_WALK_FWD, OP_WALK_BACK:
                    begin
                        front_next = (op_reg == OP_WALK_FWD) ? head_reg : tail_reg;
                        k_next     = '0;
                        if (front_next[SLOT_BITS])
                        begin
                            res_next   = mk_res(STAT_EMPTY, '0, '0, '0);
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_WALK_RD;
                        end
                    end

                    OP_REVERSE:
                    begin
                        if (head_reg[SLOT_BITS])
                        begin
                            res_next   = mk_res(STAT_EMPTY, '0, '0, '0);
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            front_next = head_reg;
                            back_next  = tail_reg;
                            i_next     = '0;
                            state_next = S_REV_RF;
                        end
                    end

                    default:
                    begin
                        res_next   = mk_res(STAT_OK, '0, '0, '0);
                        state_next = S_EMIT;
                    end
                endcase
            end

            // Insert: the anchor's successor has arrived.
            S_INS_RD:
            begin
                n_next     = rd_next_reg;
                state_next = S_INS_WR;
            end

            // Insert: write the new slot's links and tags.
            S_INS_WR:
            begin
                link_we_next = 1'b1;
                link_we_prev = 1'b1;
                link_wr_addr = s_reg;
                link_wd_next = n_reg;
                link_wd_prev = a_reg;
                pay_we       = 1'b1;
                pay_wr_addr  = s_reg;
                pay_wd_a     = tag_a_reg;
                pay_wd_b     = tag_b_reg;
                used_next[s_reg] = 1'b1;
                count_next   = cnt_t'(count_reg + 1'b1);
                if (a_reg[SLOT_BITS])
                begin
                    head_next = {1'b0, s_reg};
                end
                state_next = S_INS_A;
            end

            // Insert: point the anchor forward at the new slot.
            S_INS_A:
            begin
                if (!a_reg[SLOT_BITS])
                begin
                    link_we_next = 1'b1;
                    link_wr_addr = a_reg[SLOT_BITS-1:0];
                    link_wd_next = {1'b0, s_reg};
                end
                if (n_reg[SLOT_BITS])
                begin
                    tail_next = {1'b0, s_reg};
                end
                state_next = S_INS_N;
            end

            // Insert: point the successor back at the new slot.
            S_INS_N:
            begin
                if (!n_reg[SLOT_BITS])
                begin
                    link_we_prev = 1'b1;
                    link_wr_addr = n_reg[SLOT_BITS-1:0];
                    link_wd_prev = {1'b0, s_reg};
                end
                res_next   = mk_res(STAT_OK, s_reg, tag_a_reg, tag_b_reg);
                state_next = S_EMIT;
            end

            // Delete after: the victim is the anchor's successor, if any.
            S_DA_RD:
            begin
                if (rd_next_reg[SLOT_BITS])
                begin
                    res_next   = mk_res(STAT_ANCHOR, anchor_reg, '0, '0);
                    state_next = S_EMIT;
                end
                else
                begin
                    s_next       = rd_next_reg[SLOT_BITS-1:0];
                    link_rd_en   = 1'b1;
                    link_rd_addr = rd_next_reg[SLOT_BITS-1:0];
                    pay_rd_en    = 1'b1;
                    pay_rd_addr  = rd_next_reg[SLOT_BITS-1:0];
                    state_next   = S_DEL_RD;
                end
            end

            // Delete: unlink forward from the predecessor and free the slot.
            S_DEL_RD:
            begin
                p_next   = rd_prev_reg;
                n_next   = rd_next_reg;
                res_next = mk_res(STAT_OK, s_reg, rd_a_reg, rd_b_reg);
                if (!rd_prev_reg[SLOT_BITS])
                begin
                    link_we_next = 1'b1;
                    link_wr_addr = rd_prev_reg[SLOT_BITS-1:0];
                    link_wd_next = rd_next_reg;
                end
                else
                begin
                    head_next = rd_next_reg;
                end
                used_next[s_reg] = 1'b0;
                if (count_reg != '0)
                begin
                    count_next = cnt_t'(count_reg - 1'b1);
                end
                state_next = S_DEL_N;
            end

            // Delete: unlink backward from the successor.
            S_DEL_N:
            begin
                if (!n_reg[SLOT_BITS])
                begin
                    link_we_prev = 1'b1;
                    link_wr_addr = n_reg[SLOT_BITS-1:0];
                    link_wd_prev = p_reg;
                end
                else
                begin
                    tail_next = p_reg;
                end
                state_next = S_EMIT;
            end

            S_WALK_RD:
            begin
                link_rd_en   = 1'b1;
                link_rd_addr = front_reg[SLOT_BITS-1:0];
                pay_rd_en    = 1'b1;
                pay_rd_addr  = front_reg[SLOT_BITS-1:0];
                state_next   = S_WALK_OUT;
            end

            // Walk: send this element once the output register is free.
            S_WALK_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.status    = STAT_OK;
                    out_next.slot      = front_reg[SLOT_BITS-1:0];
                    out_next.out_tag_a = rd_a_reg;
                    out_next.out_tag_b = rd_b_reg;
                    out_next.length    = count_reg;
                    out_next.last      = walk_fin;
                    k_next             = slot_t'(k_reg + 1'b1);
                    front_next         = walk_nx;
                    state_next         = walk_fin ? S_IDLE : S_WALK_RD;
                end
            end

            // Reverse: read the front element unless the halves have met.
            S_REV_RF:
            begin
                if (i_reg >= (count_reg >> 1) || front_reg[SLOT_BITS]
                    || back_reg[SLOT_BITS])
                begin
                    res_next   = mk_res(STAT_OK, '0, '0, '0);
                    state_next = S_EMIT;
                end
                else
                begin
                    link_rd_en   = 1'b1;
                    link_rd_addr = front_reg[SLOT_BITS-1:0];
                    pay_rd_en    = 1'b1;
                    pay_rd_addr  = front_reg[SLOT_BITS-1:0];
                    state_next   = S_REV_RB;
                end
            end

            // Reverse: hold the front tags, read the back element.
            S_REV_RB:
            begin
                swap_a_next  = rd_a_reg;
                swap_b_next  = rd_b_reg;
                n_next       = rd_next_reg;
                link_rd_en   = 1'b1;
                link_rd_addr = back_reg[SLOT_BITS-1:0];
                pay_rd_en    = 1'b1;
                pay_rd_addr  = back_reg[SLOT_BITS-1:0];
                state_next   = S_REV_WF;
            end

            S_REV_WF:
            begin
                p_next      = rd_prev_reg;
                pay_we      = 1'b1;
                pay_wr_addr = front_reg[SLOT_BITS-1:0];
                pay_wd_a    = rd_a_reg;
                pay_wd_b    = rd_b_reg;
                state_next  = S_REV_WB;
            end

            // Reverse: finish the swap and move both ends inwards.
            S_REV_WB:
            begin
                pay_we      = 1'b1;
                pay_wr_addr = back_reg[SLOT_BITS-1:0];
                pay_wd_a    = swap_a_reg;
                pay_wd_b    = swap_b_reg;
                front_next  = n_reg;
                back_next   = p_reg;
                i_next      = cnt_t'(i_reg + 1'b1);
                state_next  = S_REV_RF;
            end

            // Send the single result of the transaction.
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = res_reg;
                    out_next.length = count_reg;
                    out_next.last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            head_reg      <= LINK_NULL;
            tail_reg      <= LINK_NULL;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        anchor_reg <= anchor_next;
        tag_a_reg  <= tag_a_next;
        tag_b_reg  <= tag_b_next;
        s_reg      <= s_next;
        a_reg      <= a_next;
        n_reg      <= n_next;
        p_reg      <= p_next;
        front_reg  <= front_next;
        back_reg   <= back_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        swap_a_reg <= swap_a_next;
        swap_b_reg <= swap_b_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    // Between transactions the count matches the number of used slots.
    a_count_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(used_reg) == count_reg))
        else $error("element count differs from used slots");

    // An empty list has null head and tail between transactions.
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && count_reg == '0)
        |-> (head_reg[SLOT_BITS] && tail_reg[SLOT_BITS]))
        else $error("empty list with a live head or tail");

    // The slot written by an insert is marked used straight after.
    a_ins_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_WR) |=> used_reg[$past(s_reg)])
        else $error("inserted slot not marked used");

endmodule

FILE: sv/adl_free_find.sv
// Priority encoder that finds the lowest-numbered free slot.
module adl_free_find (
    input  logic [adl_pkg::SLOTS-1:0] used,
    output adl_pkg::free_info_t       info
);
    import adl_pkg::*;

    // Scan from the top down so that the lowest free slot wins.
    always_comb
    begin
        info.found = 1'b0;
        info.slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                info.found = 1'b1;
                info.slot  = slot_t'(i);
            end
        end
    end

endmodule

FILE: dv/tb_top.sv
// Testbench for the array-based doubly linked list: random and directed operations checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
    import adl_pkg::*;

    // Scoreboard: keeps its own copy of the list and the queue of awaited results.
    class list_scoreboard;
        link_t nxt [SLOTS];
        link_t prv [SLOTS];
        bit    used [SLOTS];
        tag_t  pa [SLOTS];
        tag_t  pb [SLOTS];
        link_t head;
        link_t tail;
        int    count;
        rsp_t  awaited [$];
        int    errors;
        int    checked;

        function void clear_links();
            for (int i = 0; i < SLOTS; i++)
            begin
                nxt[i] = LINK_NULL;
                prv[i] = LINK_NULL;
                used[i] = 0;
            end
            head = LINK_NULL;
            tail = LINK_NULL;
            count = 0;
        endfunction

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                pa[i] = '0;
                pb[i] = '0;
            end
            clear_links();
            errors = 0;
            checked = 0;
        endfunction

        function void push(logic [1:0] st, int sl, tag_t ta, tag_t tb, bit fin);
            rsp_t r;
            r.status = st;
            r.slot = slot_t'(sl);
            r.out_tag_a = ta;
            r.out_tag_b = tb;
            r.length = cnt_t'(count);
            r.last = fin;
            awaited.push_back(r);
        endfunction

        function int lowest_free();
            for (int i = 0; i < SLOTS; i++)
                if (!used[i])
                    return i;
            return SLOTS;
        endfunction

        function void link_in(int anchor, tag_t ta, tag_t tb);
            int s;
            int n;
            s = lowest_free();
            n = (anchor < SLOTS) ? int'(nxt[anchor]) : int'(head);
            pa[s] = ta;
            pb[s] = tb;
            used[s] = 1;
            prv[s] = link_t'(anchor);
            nxt[s] = link_t'(n);
            if (anchor < SLOTS)
                nxt[anchor] = link_t'(s);
            else
                head = link_t'(s);
            if (n < SLOTS)
                prv[n] = link_t'(s);
            else
                tail = link_t'(s);
            count++;
            push(STAT_OK, s, ta, tb, 1);
        endfunction

        function void unlink(int s);
            int p;
            int n;
            p = prv[s];
            n = nxt[s];
            if (p < SLOTS)
                nxt[p] = link_t'(n);
            else
                head = link_t'(n);
            if (n < SLOTS)
                prv[n] = link_t'(p);
            else
                tail = link_t'(p);
            prv[s] = LINK_NULL;
            nxt[s] = LINK_NULL;
            used[s] = 0;
            if (count > 0)
                count--;
            push(STAT_OK, s, pa[s], pb[s], 1);
        endfunction

        // Notes one accepted transaction and predicts its results.
        function void note_request(req_t q);
            int s;
            int k;
            int nx;
            int front;
            int back;
            tag_t t;
            case (q.opcode)
                OP_ADD_FIRST, OP_ADD_AFTER, OP_ADD_LAST:
                begin
                    if (count >= SLOTS)
                        push(STAT_FULL, 0, '0, '0, 1);
                    else if (q.opcode == OP_ADD_AFTER)
                    begin
                        if (!used[q.anchor_slot])
                            push(STAT_ANCHOR, q.anchor_slot, '0, '0, 1);
                        else
                            link_in(q.anchor_slot, q.tag_a, q.tag_b);
                    end
                    else if (q.opcode == OP_ADD_FIRST)
                        link_in(SLOTS, q.tag_a, q.tag_b);
                    else
                        link_in(tail, q.tag_a, q.tag_b);
                end
                OP_DEL_FIRST, OP_DEL_LAST:
                begin
                    s = (q.opcode == OP_DEL_FIRST) ? int'(head) : int'(tail);
                    if (s >= SLOTS)
                        push(STAT_EMPTY, 0, '0, '0, 1);
                    else
                        unlink(s);
                end
                OP_DEL_AFTER:
                begin
                    if (!used[q.anchor_slot] || nxt[q.anchor_slot] >= SLOTS)
                        push(STAT_ANCHOR, q.anchor_slot, '0, '0, 1);
                    else
                        unlink(nxt[q.anchor_slot]);
                end
                OP_DEL_ALL:
                begin
                    clear_links();
                    push(STAT_OK, 0, '0, '0, 1);
                end
                OP_WALK_FWD, OP_WALK_BACK:
                begin
                    s = (q.opcode == OP_WALK_FWD) ? int'(head) : int'(tail);
                    if (s >= SLOTS)
                        push(STAT_EMPTY, 0, '0, '0, 1);
                    k = 0;
                    while (s < SLOTS && k < SLOTS)
                    begin
                        nx = (q.opcode == OP_WALK_FWD) ? int'(nxt[s]) : int'(prv[s]);
                        push(STAT_OK, s, pa[s], pb[s], (nx >= SLOTS || k + 1 >= SLOTS));
                        k++;
                        s = nx;
                    end
                end
                OP_REVERSE:
                begin
                    if (head >= SLOTS)
                        push(STAT_EMPTY, 0, '0, '0, 1);
                    else
                    begin
                        front = head;
                        back = tail;
                        for (int i = 0; i < count / 2; i++)
                        begin
                            t = pa[front]; pa[front] = pa[back]; pa[back] = t;
                            t = pb[front]; pb[front] = pb[back]; pb[back] = t;
                            front = nxt[front];
                            back = prv[back];
                        end
                        push(STAT_OK, 0, '0, '0, 1);
                    end
                end
                default:
                    push(STAT_OK, 0, '0, '0, 1);
            endcase
        endfunction

        // Prints one mismatch line and counts it.
        task report(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        // Compares one accepted result with the oldest prediction.
        task check_result(rsp_t r);
            rsp_t e;
            checked++;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result %p", r));
                return;
            end
            e = awaited.pop_front();
            if (r.status !== e.status || r.slot !== e.slot || r.out_tag_a !== e.out_tag_a
                || r.out_tag_b !== e.out_tag_b || r.length !== e.length || r.last !== e.last)
            begin
                report($sformatf("result %0d got %p expected %p", checked, r, e));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    list_scoreboard board;
    bit   quiet;
    int   cycles;
    int   items_sent;

    array_doubly_linked_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock generation.
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Cycle limit for the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: sample, check and stall in random bursts.
    initial
    begin
        int gap;
        rsp_stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                board.check_result(rsp);
            if (gap > 0)
                gap--;
            else if (!quiet && $urandom_range(0, 9) == 0)
                gap = $urandom_range(1, 15);
            rsp_stall <= (gap > 0);
        end
    end

    // Sends one transaction and waits for its acceptance; valid stays up for the next one.
    task automatic send_item(logic [3:0] op, slot_t anchor, tag_t ta, tag_t tb);
        req_t q;
        int idle;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            idle = $urandom_range(1, 15);
            req_valid <= 0;
            repeat (idle) @(posedge clk);
        end
        q.opcode = op;
        q.anchor_slot = anchor;
        q.tag_a = ta;
        q.tag_b = tb;
        req <= q;
        req_valid <= 1;
        do
            @(posedge clk);
        while (req_stall);
        board.note_request(q);
        items_sent++;
    endtask

    // Drops valid and waits until every predicted result has arrived.
    task automatic drain();
        req_valid <= 0;
        do
            @(posedge clk);
        while (board.awaited.size() != 0);
    endtask

    // Picks an anchor, mostly a used slot.
    function automatic slot_t pick_anchor();
        int tries;
        slot_t a;
        for (tries = 0; tries < 8; tries++)
        begin
            a = slot_t'($urandom_range(0, SLOTS - 1));
            if (board.used[a])
                return a;
        end
        return a;
    endfunction

    initial
    begin
        int pick;
        logic [3:0] op;
        board = new();
        quiet = 0;
        cycles = 0;
        items_sent = 0;
        rst_n = 0;
        req_valid = 0;
        req = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: empty cases, extremes of tags, fill to full, walks and reverse.
        send_item(OP_DEL_FIRST, 0, '0, '0);
        send_item(OP_DEL_LAST, 0, '0, '0);
        send_item(OP_WALK_FWD, 0, '0, '0);
        send_item(OP_REVERSE, 0, '0, '0);
        send_item(OP_ADD_AFTER, 4'd15, '1, '1);
        send_item(OP_DEL_AFTER, 4'd7, '0, '0);
        send_item(OP_ADD_FIRST, 0, '1, '0);
        send_item(OP_ADD_LAST, 4'd15, '0, '1);
        send_item(OP_DEL_AFTER, 4'd1, '0, '0);
        for (int i = 0; i < SLOTS - 2; i++)
            send_item(OP_ADD_AFTER, 0, $urandom, $urandom);
        send_item(OP_ADD_LAST, 0, '1, '1);
        send_item(OP_WALK_FWD, 0, '0, '0);
        send_item(OP_REVERSE, 0, '0, '0);
        send_item(OP_WALK_BACK, 0, '0, '0);
        send_item(OP_DEL_AFTER, 0, '0, '0);
        send_item(OP_DEL_FIRST, 0, '0, '0);
        send_item(OP_COUNT, 0, '0, '0);
        send_item(4'd15, 4'd15, '1, '1);
        send_item(OP_DEL_ALL, 0, '0, '0);

        // Hold the sender until the block has emptied its results.
        drain();

        // Random part: mostly inserts and deletes, with walks and odd codes mixed in.
        for (int n = 0; n < 280; n++)
        begin
            if (n == 230)
                quiet = 1;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                op = 4'($urandom_range(0, 2));
            else if (pick < 60)
                op = 4'($urandom_range(3, 5));
            else if (pick < 63)
                op = OP_DEL_ALL;
            else if (pick < 90)
                op = 4'($urandom_range(7, 10));
            else
                op = 4'($urandom_range(11, 15));
            send_item(op, ($urandom_range(0, 3) == 0) ? slot_t'($urandom) : pick_anchor(),
                      $urandom, $urandom);
            if (n == 120)
                drain();
        end

        drain();
        repeat (50) @(posedge clk);
        $display("Ran %0d transactions and checked %0d results, covering every operation,",
                 items_sent, board.checked);
        $display("full and empty lists, bad anchors, walks both ways and reversal.");
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
